FILE: rtl/core/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg: shared types, constants and font for the scrolling text marquee
// Item and result structs, queue entry and column handoff types, the 5x7 font.
// ----------------------------------------------------------------------------
package stm_pkg;

	localparam int TEXT_DEPTH_DEF  = 128;
	localparam int WINDOW_COLS_DEF = 32;
	localparam int GLYPH_COLS_DEF  = 5;
	localparam int QUEUE_DEPTH     = 4;
	localparam int ROWS            = 8;

	localparam logic [7:0] CH_START   = 8'h24;
	localparam logic [7:0] CH_END     = 8'h3B;
	localparam logic [7:0] FONT_FIRST = 8'd32;
	localparam logic [7:0] FONT_LAST  = 8'd127;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} stm_in_t;

	typedef struct packed {
		logic [2:0]  row_index;
		logic [31:0] row_bits;
		logic        last_row;
	} stm_out_t;

	// queue entry, pre-decoded by the front
	typedef struct packed {
		logic       is_tick;
		logic       is_start;
		logic       is_end;
		logic [7:0] data;
	} stm_op_t;

	// column handed from control to the row emitter
	typedef struct packed {
		logic       valid;
		logic [7:0] bits;
	} stm_col_t;

	// five columns per glyph, first column in the top byte
	localparam logic [39:0] GLYPHS [96] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h8080808080,
		40'h0003070000, 40'h2054545478, 40'h7F44444438, 40'h3844444444,
		40'h384444447F, 40'h3854545418, 40'h04047E0505, 40'h085454543C,
		40'h7F08080870, 40'h00007D0000, 40'h408080807D, 40'h7F10102844,
		40'h00007F0000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
		40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h0854545420,
		40'h04043F4444, 40'h3C4040407C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h0448300804, 40'h4464544C44, 40'h0836410000,
		40'h00007F0000, 40'h0000413608, 40'h0804081008, 40'h0000000000
	};

	function automatic logic is_printable(input logic [7:0] ch);
		is_printable = (ch >= FONT_FIRST) && (ch <= FONT_LAST);
	endfunction

	function automatic logic [7:0] glyph_col(input logic [7:0] ch, input logic [2:0] col);
		logic [6:0]  idx;
		logic [39:0] g;
		idx = 7'(ch - FONT_FIRST);
		g   = GLYPHS[idx];
		unique case (col)
			3'd0:    glyph_col = g[39:32];
			3'd1:    glyph_col = g[31:24];
			3'd2:    glyph_col = g[23:16];
			3'd3:    glyph_col = g[15:8];
			3'd4:    glyph_col = g[7:0];
			default: glyph_col = 8'h00;
		endcase
	endfunction

endpackage

FILE: rtl/core/stm_front.sv
// ----------------------------------------------------------------------------
// stm_front: item intake and classification
// Decodes each accepted item and places it in a short queue for the control.
// ----------------------------------------------------------------------------
module stm_front import stm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  stm_in_t item,
	output stm_op_t op,
	output logic    op_valid,
	input  logic    op_pop
);

	localparam int QAW = $clog2(QUEUE_DEPTH);

	stm_op_t        queue_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           pop;
	stm_op_t        entry;

	assign item_ready = (count_q != (QAW+1)'(QUEUE_DEPTH));
	assign op_valid   = (count_q != '0);
	assign op         = queue_q[rd_ptr_q];
	assign push       = item_valid && item_ready;
	assign pop        = op_pop && op_valid;

	always_comb begin
		entry.is_tick  = (item.command == CMD_TICK);
		entry.is_start = (item.rx_byte == CH_START);
		entry.is_end   = (item.rx_byte == CH_END);
		entry.data     = item.rx_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/stm_ctrl.sv
// ----------------------------------------------------------------------------
// stm_ctrl: framing and scroll control
// Runs the '$' text ';' framing into the text memory and picks each tick's column.
// ----------------------------------------------------------------------------
module stm_ctrl import stm_pkg::*; #(
	parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
	parameter int WINDOW_COLS = WINDOW_COLS_DEF,
	parameter int GLYPH_COLS  = GLYPH_COLS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  stm_op_t  op,
	input  logic     op_valid,
	output logic     op_pop,
	output stm_col_t col,
	input  logic     col_ready
);

	localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int LW = $clog2(TEXT_DEPTH + 1);
	localparam int FW = $clog2(TEXT_DEPTH + 2);
	localparam int BW = $clog2(WINDOW_COLS + 1);
	localparam logic [2:0] GCOLS = 3'(GLYPH_COLS);

	typedef enum logic {ST_IDLE, ST_LOOK} state_t;

	state_t         state_q;
	logic [FW-1:0]  frame_count_q;
	logic           lead_start_q;
	logic [LW-1:0]  text_length_q;
	logic [LW-1:0]  char_pos_q;
	logic [2:0]     col_in_q;
	logic [BW-1:0]  blank_left_q;
	logic [7:0]     text_mem_q [TEXT_DEPTH];
	logic [7:0]     rd_data_q;

	logic           mem_we;
	logic           rd_en;
	logic [AW-1:0]  wr_addr;
	logic           text_done;
	logic           printable;

	assign wr_addr   = AW'(frame_count_q - FW'(1));
	assign text_done = (char_pos_q >= text_length_q);
	assign printable = is_printable(rd_data_q);

	always_comb begin
		op_pop   = 1'b0;
		col      = '0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					if (!op.is_tick) begin
						op_pop = 1'b1;
						mem_we = (frame_count_q != '0) && lead_start_q && !op.is_end &&
							(frame_count_q <= FW'(TEXT_DEPTH));
					end else if (text_done) begin
						if (blank_left_q != '0) begin
							col.valid = 1'b1;
							op_pop    = col_ready;
						end else begin
							op_pop = 1'b1;
						end
					end else begin
						op_pop = 1'b1;
						rd_en  = 1'b1;
					end
				end
			end
			ST_LOOK: begin
				if (printable) begin
					col.valid = 1'b1;
					col.bits  = (col_in_q < GCOLS) ? glyph_col(rd_data_q, col_in_q) : 8'h00;
				end
			end
			default: begin
				op_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			text_mem_q[wr_addr] <= op.data;
		end
		if (rd_en) begin
			rd_data_q <= text_mem_q[char_pos_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_count_q <= '0;
			lead_start_q  <= 1'b0;
			text_length_q <= '0;
			char_pos_q    <= '0;
			col_in_q      <= '0;
			blank_left_q  <= BW'(WINDOW_COLS);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (op_pop) begin
						if (!op.is_tick) begin
							if (frame_count_q == '0) begin
								lead_start_q  <= op.is_start;
								frame_count_q <= FW'(1);
							end else if (lead_start_q && op.is_end) begin
								if (frame_count_q > FW'(1)) begin
									text_length_q <= LW'(frame_count_q - FW'(1));
								end
								frame_count_q <= '0;
								lead_start_q  <= 1'b0;
							end else if (lead_start_q && frame_count_q <= FW'(TEXT_DEPTH)) begin
								frame_count_q <= frame_count_q + 1'b1;
							end else begin
								// overflow, or any leader other than '$'
								frame_count_q <= '0;
								lead_start_q  <= 1'b0;
							end
						end else if (text_done) begin
							if (blank_left_q != '0) begin
								blank_left_q <= blank_left_q - 1'b1;
							end else begin
								// silent tick: restart the scroll
								char_pos_q   <= '0;
								col_in_q     <= '0;
								blank_left_q <= BW'(WINDOW_COLS);
							end
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					if (!printable) begin
						char_pos_q <= char_pos_q + 1'b1;
						col_in_q   <= '0;
						state_q    <= ST_IDLE;
					end else if (col_ready) begin
						if (col_in_q == GCOLS) begin
							col_in_q   <= '0;
							char_pos_q <= char_pos_q + 1'b1;
						end else begin
							col_in_q <= col_in_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/stm_emit.sv
// ----------------------------------------------------------------------------
// stm_emit: window shifter and row emitter
// Shifts one row per unstalled cycle by the new column and registers it as a result.
// ----------------------------------------------------------------------------
module stm_emit import stm_pkg::*; #(
	parameter int WINDOW_COLS = WINDOW_COLS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  stm_col_t col,
	output logic     col_ready,
	output logic     result_valid,
	input  logic     result_ready,
	output stm_out_t result
);

	logic [WINDOW_COLS-1:0] win_q [ROWS];
	logic                   active_q;
	logic [2:0]             row_q;
	logic [7:0]             bits_q;
	logic                   result_valid_q;
	stm_out_t               result_q;

	logic                   advance;
	logic                   take;
	logic                   last;
	logic [WINDOW_COLS-1:0] shifted;

	assign advance      = active_q && (!result_valid_q || result_ready);
	assign last         = (row_q == 3'(ROWS - 1));
	assign col_ready    = !active_q || (advance && last);
	assign take         = col.valid && col_ready;
	assign shifted      = {win_q[row_q][WINDOW_COLS-2:0], bits_q[row_q]};
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (take) begin
			bits_q <= col.bits;
		end
		if (advance) begin
			result_q.row_index <= row_q;
			result_q.row_bits  <= 32'(shifted);
			result_q.last_row  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				win_q[r] <= '0;
			end
			active_q       <= 1'b0;
			row_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				win_q[row_q]   <= shifted;
				row_q          <= row_q + 1'b1;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (take) begin
				active_q <= 1'b1;
			end else if (advance && last) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/scrolling_text_marquee.sv
// A shifting tick passes the intake queue, the control (which reads the text memory first for a font
// column) and the emitter's column register before its first row is registered in the result.
// The emitter shifts and sends one row a cycle unless stalled at the output; eight rows per shifting tick.
// Control handles a byte in the idle state alone; a tick with no rows may also pass the look state.
// Items queue ahead of the control (4 entries), so intake goes on during row output.
// Reset clears window, framing and scroll state; the text memory is not cleared.
// ----------------------------------------------------------------------------
// scrolling_text_marquee: scrolling text for an 8-row LED window
// Bytes frame text as '$' text ';'; ticks scroll the window one column left, save those that skip or restart.
// ----------------------------------------------------------------------------
module scrolling_text_marquee import stm_pkg::*; #(
	parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
	parameter int WINDOW_COLS = WINDOW_COLS_DEF,
	parameter int GLYPH_COLS  = GLYPH_COLS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  stm_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output stm_out_t result
);

	stm_op_t  op;
	logic     op_valid;
	logic     op_pop;
	stm_col_t col;
	logic     col_ready;

	stm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.op         (op),
		.op_valid   (op_valid),
		.op_pop     (op_pop)
	);

	stm_ctrl #(
		.TEXT_DEPTH  (TEXT_DEPTH),
		.WINDOW_COLS (WINDOW_COLS),
		.GLYPH_COLS  (GLYPH_COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.op_valid  (op_valid),
		.op_pop    (op_pop),
		.col       (col),
		.col_ready (col_ready)
	);

	stm_emit #(
		.WINDOW_COLS (WINDOW_COLS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.col          (col),
		.col_ready    (col_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the scrolling text marquee
// Frames text in with '$' ... ';' byte sequences and scrolls it with ticks.
// Every row word is checked against a local model of the framing and the scroll.
// ----------------------------------------------------------------------------
module tb_top;
	import stm_pkg::*;

	localparam int TEXT_DEPTH   = 128;
	localparam int WINDOW_COLS  = 32;
	localparam int GLYPH_COLS   = 5;
	localparam int LIMIT        = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 20;

	localparam logic [7:0] CH_HASH = 8'h23;

	// 5x7 font, printable 32..127, first column in the top byte
	localparam logic [39:0] FONT_COLS [96] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h8080808080,
		40'h0003070000, 40'h2054545478, 40'h7F44444438, 40'h3844444444,
		40'h384444447F, 40'h3854545418, 40'h04047E0505, 40'h085454543C,
		40'h7F08080870, 40'h00007D0000, 40'h408080807D, 40'h7F10102844,
		40'h00007F0000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
		40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h0854545420,
		40'h04043F4444, 40'h3C4040407C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h0448300804, 40'h4464544C44, 40'h0836410000,
		40'h00007F0000, 40'h0000413608, 40'h0804081008, 40'h0000000000
	};

	// hold entries make the sender wait until every row has come back
	typedef struct packed {
		logic    hold;
		stm_in_t data;
	} feed_t;

	logic     clk;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_ready;
	stm_in_t  item         = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	stm_out_t result;

	feed_t    feed_q [$];
	stm_out_t rows_due [$];

	// marquee state as the block should hold it
	logic [31:0] win [8];
	logic [7:0]  text_mem [TEXT_DEPTH];
	logic [7:0]  text_len;
	logic [7:0]  char_pos;
	logic [2:0]  col_idx;
	logic [5:0]  blanks_left;
	logic [7:0]  frame_cnt;
	logic [7:0]  leader;

	int items_queued;
	int items_taken;
	int ticks_taken;
	int rows_checked;
	int frames_committed;
	int frames_overflowed;
	int errors;
	bit quiet;

	scrolling_text_marquee DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shift one font column into the window and expect all eight rows
	function automatic void shift_column(logic [7:0] column);
		stm_out_t row;
		for (int r = 0; r < 8; r++) begin
			win[r] = {win[r][30:0], column[r]};
			row.row_index = 3'(r);
			row.row_bits  = win[r];
			row.last_row  = (r == 7);
			rows_due.push_back(row);
		end
	endfunction

	function automatic void scroll_tick();
		logic [7:0]  ch;
		logic [7:0]  column;
		logic [39:0] glyph;
		ticks_taken++;
		if (char_pos >= text_len) begin
			if (blanks_left > 0) begin
				blanks_left--;
				shift_column(8'h00);
			end else begin
				// silent tick, scroll restarts at the first character
				char_pos    = '0;
				col_idx     = '0;
				blanks_left = 6'(WINDOW_COLS);
			end
			return;
		end
		ch = text_mem[char_pos];
		if (ch < FONT_FIRST || ch > FONT_LAST) begin
			char_pos++;
			col_idx = '0;
			return;
		end
		column = 8'h00;
		if (col_idx < GLYPH_COLS) begin
			glyph  = FONT_COLS[ch - FONT_FIRST];
			column = 8'(glyph >> (8 * (4 - col_idx)));
		end
		shift_column(column);
		col_idx++;
		if (col_idx > GLYPH_COLS) begin
			col_idx = '0;
			char_pos++;
		end
	endfunction

	function automatic void frame_byte(logic [7:0] b);
		if (frame_cnt == 0) begin
			leader    = b;
			frame_cnt = 8'd1;
		end else if (leader == CH_START) begin
			if (b == CH_END) begin
				if (frame_cnt > 1) begin
					text_len = frame_cnt - 8'd1;
					frames_committed++;
				end
				frame_cnt = '0;
				leader    = '0;
			end else if (frame_cnt <= TEXT_DEPTH) begin
				text_mem[frame_cnt - 8'd1] = b;
				frame_cnt++;
			end else begin
				frames_overflowed++;
				frame_cnt = '0;
				leader    = '0;
			end
		end else begin
			frame_cnt = '0;
			leader    = '0;
		end
	endfunction

	task automatic queue_byte(logic [7:0] b);
		feed_t f;
		f.hold         = 1'b0;
		f.data.command = CMD_BYTE;
		f.data.rx_byte = b;
		feed_q.push_back(f);
		items_queued++;
	endtask

	task automatic queue_ticks(int n);
		feed_t f;
		f.hold         = 1'b0;
		f.data.command = CMD_TICK;
		for (int i = 0; i < n; i++) begin
			// rx_byte is a don't-care on ticks, so let it wander
			f.data.rx_byte = 8'($urandom_range(255));
			feed_q.push_back(f);
			items_queued++;
		end
	endtask

	task automatic queue_hold();
		feed_t f;
		f      = '0;
		f.hold = 1'b1;
		feed_q.push_back(f);
	endtask

	// frame body: mostly printable, some of anything but the end mark
	task automatic queue_text(int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 82)
				b = 8'($urandom_range(FONT_LAST, FONT_FIRST));
			else begin
				b = 8'($urandom_range(255));
				if (b == CH_END)
					b = 8'h00;
			end
			queue_byte(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		feed_t head;
		if (!arst_n) begin
			item_valid   <= 1'b0;
			item         <= '0;
			result_ready <= 1'b0;
		end else begin
			if (!item_valid || item_ready) begin
				if (feed_q.size() > 0 && feed_q[0].hold) begin
					if (!item_valid && rows_due.size() == 0)
						void'(feed_q.pop_front());
					item_valid <= 1'b0;
				end else if (feed_q.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
					head = feed_q.pop_front();
					item       <= head.data;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= quiet || ($urandom_range(99) >= 13);
		end
	end

	always @(posedge clk) begin : observe
		stm_out_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				rows_checked++;
				if (rows_due.size() == 0) begin
					$error("row result with none expected: row_index %0d row_bits %h",
						result.row_index, result.row_bits);
					errors++;
				end else begin
					want = rows_due.pop_front();
					if (result.row_index !== want.row_index) begin
						$error("row_index: expected %0d, got %0d", want.row_index,
							result.row_index);
						errors++;
					end
					if (result.row_bits !== want.row_bits) begin
						$error("row_bits: expected %h, got %h", want.row_bits, result.row_bits);
						errors++;
					end
					if (result.last_row !== want.last_row) begin
						$error("last_row: expected %0b, got %0b", want.last_row, result.last_row);
						errors++;
					end
				end
			end
			// an item taken at this edge cannot have a row out yet
			if (item_valid && item_ready) begin
				if (item.command == CMD_BYTE)
					frame_byte(item.rx_byte);
				else
					scroll_tick();
				items_taken++;
				quiet = (items_taken >= 150 && items_taken < 260);
			end
		end
	end

	initial begin : watchdog
		repeat (LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int start;
		int kind;
		bit held;
		for (int r = 0; r < 8; r++)
			win[r] = '0;
		for (int i = 0; i < TEXT_DEPTH; i++)
			text_mem[i] = '0;
		text_len    = '0;
		char_pos    = '0;
		col_idx     = '0;
		blanks_left = 6'(WINDOW_COLS);
		frame_cnt   = '0;
		leader      = '0;

		// empty text scrolls blanks, then a frame with edge characters
		queue_ticks(2);
		queue_byte(CH_START);
		queue_byte(FONT_FIRST);
		queue_byte(8'h41);
		queue_byte(8'h1F);
		queue_byte(8'h80);
		queue_byte(FONT_LAST);
		queue_byte(8'hFF);
		queue_byte(CH_END);
		// '#' leader swallows the next byte, even a start mark
		queue_byte(CH_HASH);
		queue_byte(CH_START);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		// empty frame keeps the old text
		queue_byte(CH_START);
		queue_byte(CH_END);
		queue_byte(CH_END);
		queue_byte(8'h42);
		queue_ticks(7);
		queue_hold();

		// full store, then a frame that runs past it
		queue_byte(CH_START);
		queue_text(TEXT_DEPTH);
		queue_byte(CH_END);
		queue_ticks(10);
		queue_byte(CH_START);
		queue_text(TEXT_DEPTH + 1);
		queue_ticks(5);
		queue_hold();

		start = items_queued;
		held  = 1'b0;
		while (items_queued - start < RANDOM_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				queue_byte(CH_START);
				queue_text(($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1));
				queue_byte(CH_END);
			end else if (kind < 80) begin
				queue_ticks(($urandom_range(6) == 0) ? $urandom_range(110, 60) :
					$urandom_range(30, 1));
			end else if (kind < 92) begin
				queue_byte(8'($urandom_range(255)));
				if ($urandom_range(1))
					queue_byte(8'($urandom_range(255)));
			end else begin
				// frame left open, later bytes run into it
				queue_byte(CH_START);
				queue_text($urandom_range(5, 1));
				if ($urandom_range(1))
					queue_byte(CH_HASH);
			end
			if (!held && items_queued - start > RANDOM_ITEMS / 2) begin
				queue_hold();
				held = 1'b1;
			end
		end

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_taken != items_queued)
			@(posedge clk);
		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d ticks, %0d row results checked", items_taken,
			ticks_taken, rows_checked);
		$display("text frames: %0d committed, %0d dropped on overflow", frames_committed,
			frames_overflowed);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
